// ===== design/yuv_dominant_color_counter_defines.svh =====
// ============================================================================
// Assertion macros for the YUV dominant colour counter
// Shared concurrent assertion forms, clocked on clk and held off during reset.
// ============================================================================
`ifndef YUV_DOMINANT_COLOR_COUNTER_DEFINES_SVH
`define YUV_DOMINANT_COLOR_COUNTER_DEFINES_SVH

// A condition that must hold at every clock edge out of reset.
`define YUVDC_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// A condition that must hold in the cycle after a trigger.
`define YUVDC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/yuvdc_pkg.sv =====
// ============================================================================
// YUV dominant colour counter package
// Shared constants, register codes and the queue word type.
// ============================================================================
package yuvdc_pkg;

    localparam int TABLE_ENTRIES_DEF = 1024;
    localparam int MAX_REPORTED_DEF  = 16;
    localparam int COUNT_WIDTH_DEF   = 22;

    // The rank field is four bits wide, so no more than sixteen are reported.
    localparam int RANK_LIMIT = 16;
    localparam int RANK_W     = 4;
    localparam int COLOR_W    = 24;
    localparam int TOPC_W     = 5;

    localparam logic [TOPC_W-1:0] TOP_COUNT_RESET = 5'd8;
    localparam logic              SKIP_RESET      = 1'b1;

    // Configuration register indexes.
    localparam logic CFG_TOP_COUNT = 1'b0;
    localparam logic CFG_SKIP      = 1'b1;

    // One word passed from the front to the back.
    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic               counted;
        logic               frame_end;
    } pix_word_t;

endpackage

// ===== design/yuvdc_front.sv =====
// ============================================================================
// YUV dominant colour counter front end
// Accepts pixel words, applies the chroma skip and converts YUV to RGB888.
// ============================================================================
module yuvdc_front
(
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [7:0]           luma,
    input  logic [7:0]           chroma_blue,
    input  logic [7:0]           chroma_red,
    input  logic                 frame_end,
    input  logic                 skip_zero_chroma,
    input  logic                 q_full,
    output logic                 q_push,
    output yuvdc_pkg::pix_word_t q_word
);

    logic signed [21:0] ys;
    logic signed [21:0] us;
    logic signed [21:0] vs;
    logic signed [21:0] r_raw;
    logic signed [21:0] g_raw;
    logic signed [21:0] b_raw;

    // Clamp a channel to 0..262143 and keep bits 17..10.
    function automatic logic [7:0] chan8(input logic signed [21:0] x);
        logic [7:0] res;
        if (x < 22'sd0)
        begin
            res = 8'd0;
        end
        else if (x > 22'sd262143)
        begin
            res = 8'hFF;
        end
        else
        begin
            res = x[17:10];
        end
        return res;
    endfunction

    // Fixed-point colour conversion with chroma offsets removed.
    always_comb
    begin
        ys    = $signed({14'd0, luma}) * 22'sd1192;
        us    = $signed({14'd0, chroma_blue}) - 22'sd128;
        vs    = $signed({14'd0, chroma_red}) - 22'sd128;
        r_raw = ys + vs * 22'sd1634;
        g_raw = ys - vs * 22'sd833 - us * 22'sd400;
        b_raw = ys + us * 22'sd2066;
    end

    // The queue takes a word whenever it has room.
    assign in_stall          = q_full;
    assign q_push            = in_valid && !q_full;
    assign q_word.color      = {chan8(r_raw), chan8(g_raw), chan8(b_raw)};
    assign q_word.counted    = !(skip_zero_chroma && (chroma_blue == 8'd0)
                                 && (chroma_red == 8'd0));
    assign q_word.frame_end  = frame_end;

endmodule

// ===== design/yuvdc_fifo.sv =====
// ============================================================================
// YUV dominant colour counter queue
// A four-word queue that decouples the front end from the table engine.
// ============================================================================
module yuvdc_fifo
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  yuvdc_pkg::pix_word_t push_word,
    output logic                 full,
    input  logic                 pop,
    output yuvdc_pkg::pix_word_t pop_word,
    output logic                 empty
);

    yuvdc_pkg::pix_word_t mem_reg [4];
    logic [1:0] wr_reg;
    logic [1:0] wr_next;
    logic [1:0] rd_reg;
    logic [1:0] rd_next;
    logic [2:0] cnt_reg;
    logic [2:0] cnt_next;

    assign full     = (cnt_reg == 3'd4);
    assign empty    = (cnt_reg == 3'd0);
    assign pop_word = mem_reg[rd_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_next  = push ? wr_reg + 2'd1 : wr_reg;
        rd_next  = pop ? rd_reg + 2'd1 : rd_reg;
        cnt_next = cnt_reg + {2'd0, push} - {2'd0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 2'd0;
            rd_reg  <= 2'd0;
            cnt_reg <= 3'd0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // Word storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= push_word;
        end
    end

endmodule

// ===== design/yuvdc_back.sv =====
// ============================================================================
// YUV dominant colour counter table engine
// Searches and updates the colour table, then ranks and emits the report.
// ============================================================================
`include "yuv_dominant_color_counter_defines.svh"

module yuvdc_back
#(
    parameter int TABLE_ENTRIES = yuvdc_pkg::TABLE_ENTRIES_DEF,
    parameter int MAX_REPORTED  = yuvdc_pkg::MAX_REPORTED_DEF,
    parameter int COUNT_WIDTH   = yuvdc_pkg::COUNT_WIDTH_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_empty,
    input  yuvdc_pkg::pix_word_t         q_word,
    output logic                         q_pop,
    input  logic [yuvdc_pkg::TOPC_W-1:0] top_count,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [yuvdc_pkg::COLOR_W-1:0] rgb_color,
    output logic [COUNT_WIDTH-1:0]       occurrences,
    output logic [yuvdc_pkg::RANK_W-1:0] rank,
    output logic                         last_of_report,
    output logic                         table_overflow,
    output logic                         empty_frame
);

    localparam int IDX_W   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int USED_W  = $clog2(TABLE_ENTRIES + 1);
    localparam int LIST_N  = (MAX_REPORTED < yuvdc_pkg::RANK_LIMIT) ?
                             MAX_REPORTED : yuvdc_pkg::RANK_LIMIT;
    localparam int LPOS_W  = $clog2(LIST_N + 1);
    localparam int LIDX_W  = (LIST_N > 1) ? $clog2(LIST_N) : 1;
    localparam int CW      = yuvdc_pkg::COLOR_W;
    localparam int RW      = yuvdc_pkg::RANK_W;
    localparam logic [USED_W-1:0] FULL_USED = USED_W'(TABLE_ENTRIES);
    localparam logic [5:0]        LIST_LIM  = 6'(LIST_N);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_RD   = 6'b000010,
        S_CMP  = 6'b000100,
        S_RRD  = 6'b001000,
        S_RCMP = 6'b010000,
        S_EMIT = 6'b100000
    } state_t;

    state_t                state_reg, state_next;
    logic [USED_W-1:0]     idx_reg, idx_next;
    logic [USED_W-1:0]     used_reg, used_next;
    logic                  ovf_reg, ovf_next;
    yuvdc_pkg::pix_word_t  cur_reg, cur_next;
    logic [LPOS_W-1:0]     lcnt_reg, lcnt_next;
    logic [LPOS_W-1:0]     emit_reg, emit_next;
    logic [CW-1:0]          lc_reg [LIST_N];
    logic [CW-1:0]          lc_next [LIST_N];
    logic [COUNT_WIDTH-1:0] ln_reg [LIST_N];
    logic [COUNT_WIDTH-1:0] ln_next [LIST_N];

    // Table memories and their registered read data.
    logic [CW-1:0]          color_mem [TABLE_ENTRIES];
    logic [COUNT_WIDTH-1:0] count_mem [TABLE_ENTRIES];
    logic [CW-1:0]          rd_color;
    logic [COUNT_WIDTH-1:0] rd_count;
    logic                   mem_rd;
    logic                   mem_we;
    logic [IDX_W-1:0]       mem_waddr;
    logic [CW-1:0]          mem_wcolor;
    logic [COUNT_WIDTH-1:0] mem_wcount;

    // Output register.
    logic                   out_valid_reg;
    logic [CW-1:0]          color_out_reg;
    logic [COUNT_WIDTH-1:0] count_out_reg;
    logic [RW-1:0]          rank_out_reg;
    logic                   last_out_reg;
    logic                   ovf_out_reg;
    logic                   empty_out_reg;
    logic                   out_load;
    logic [CW-1:0]          color_out_next;
    logic [COUNT_WIDTH-1:0] count_out_next;
    logic                   last_out_next;
    logic                   ovf_out_next;
    logic                   empty_out_next;

    logic [5:0]             lim_wide;
    logic [LPOS_W-1:0]      limit;
    logic [LPOS_W-1:0]      ins_pos;
    logic                   done_frame;

    // Effective report length: zero acts as one, capped by the list size.
    always_comb
    begin
        lim_wide = {1'b0, top_count};
        if (lim_wide == 6'd0)
        begin
            lim_wide = 6'd1;
        end
        if (lim_wide > LIST_LIM)
        begin
            lim_wide = LIST_LIM;
        end
        limit = LPOS_W'(lim_wide);
    end

    // Insertion point: after every listed entry whose count is not smaller.
    always_comb
    begin
        ins_pos = '0;
        for (int j = 0; j < LIST_N; j++)
        begin
            if ((LPOS_W'(j) < lcnt_reg) && (ln_reg[j] >= rd_count))
            begin
                ins_pos = ins_pos + LPOS_W'(1);
            end
        end
    end

    assign out_load = !out_valid_reg || !out_stall;

    // Sequencer for lookup, ranking and emission.
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        used_next      = used_reg;
        ovf_next       = ovf_reg;
        cur_next       = cur_reg;
        lcnt_next      = lcnt_reg;
        emit_next      = emit_reg;
        lc_next        = lc_reg;
        ln_next        = ln_reg;
        q_pop          = 1'b0;
        mem_rd         = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = idx_reg[IDX_W-1:0];
        mem_wcolor     = cur_reg.color;
        mem_wcount     = rd_count;
        done_frame     = 1'b0;
        color_out_next = '0;
        count_out_next = '0;
        last_out_next  = 1'b0;
        ovf_out_next   = 1'b0;
        empty_out_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop    = 1'b1;
                    cur_next = q_word;
                    idx_next = '0;
                    if (q_word.counted)
                    begin
                        state_next = S_RD;
                    end
                    else if (q_word.frame_end)
                    begin
                        lcnt_next  = '0;
                        state_next = S_RRD;
                    end
                end
            end
            S_RD:
            begin
                if (idx_reg == used_reg)
                begin
                    // Colour not present: append it or note the overflow.
                    if (used_reg < FULL_USED)
                    begin
                        mem_we     = 1'b1;
                        mem_waddr  = used_reg[IDX_W-1:0];
                        mem_wcount = COUNT_WIDTH'(1);
                        used_next  = used_reg + USED_W'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    done_frame = 1'b1;
                end
                else
                begin
                    mem_rd     = 1'b1;
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                if (rd_color == cur_reg.color)
                begin
                    mem_we = 1'b1;
                    if (rd_count != {COUNT_WIDTH{1'b1}})
                    begin
                        mem_wcount = rd_count + COUNT_WIDTH'(1);
                    end
                    done_frame = 1'b1;
                end
                else
                begin
                    idx_next   = idx_reg + USED_W'(1);
                    state_next = S_RD;
                end
            end
            S_RRD:
            begin
                if (idx_reg == used_reg)
                begin
                    emit_next  = '0;
                    state_next = S_EMIT;
                end
                else
                begin
                    mem_rd     = 1'b1;
                    state_next = S_RCMP;
                end
            end
            S_RCMP:
            begin
                // Stable insertion into the sorted short list.
                if (ins_pos < limit)
                begin
                    for (int j = 0; j < LIST_N; j++)
                    begin
                        if (LPOS_W'(j) == ins_pos)
                        begin
                            lc_next[j] = rd_color;
                            ln_next[j] = rd_count;
                        end
                        else if (LPOS_W'(j) > ins_pos)
                        begin
                            lc_next[j] = lc_reg[(j == 0) ? 0 : j - 1];
                            ln_next[j] = ln_reg[(j == 0) ? 0 : j - 1];
                        end
                    end
                    if (lcnt_reg < limit)
                    begin
                        lcnt_next = lcnt_reg + LPOS_W'(1);
                    end
                end
                idx_next   = idx_reg + USED_W'(1);
                state_next = S_RRD;
            end
            S_EMIT:
            begin
                if (out_load)
                begin
                    if (used_reg == '0)
                    begin
                        last_out_next  = 1'b1;
                        empty_out_next = 1'b1;
                    end
                    else
                    begin
                        color_out_next = lc_reg[emit_reg[LIDX_W-1:0]];
                        count_out_next = ln_reg[emit_reg[LIDX_W-1:0]];
                        ovf_out_next   = ovf_reg;
                        last_out_next  = (emit_reg + LPOS_W'(1) == lcnt_reg);
                    end
                    emit_next = emit_reg + LPOS_W'(1);
                    if (last_out_next)
                    begin
                        used_next  = '0;
                        ovf_next   = 1'b0;
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Pixel finished: either return for the next or start the report.
        if (done_frame)
        begin
            idx_next   = '0;
            lcnt_next  = '0;
            state_next = cur_reg.frame_end ? S_RRD : S_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            used_reg      <= '0;
            ovf_reg       <= 1'b0;
            lcnt_reg      <= '0;
            emit_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            used_reg  <= used_next;
            ovf_reg   <= ovf_next;
            lcnt_reg  <= lcnt_next;
            emit_reg  <= emit_next;
            if ((state_reg == S_EMIT) && out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        lc_reg  <= lc_next;
        ln_reg  <= ln_next;
        if ((state_reg == S_EMIT) && out_load)
        begin
            color_out_reg <= color_out_next;
            count_out_reg <= count_out_next;
            rank_out_reg  <= RW'(emit_reg);
            last_out_reg  <= last_out_next;
            ovf_out_reg   <= ovf_out_next;
            empty_out_reg <= empty_out_next;
        end
    end

    // Table memories: one read and one write port.
    always_ff @(posedge clk)
    begin
        if (mem_rd)
        begin
            rd_color <= color_mem[idx_reg[IDX_W-1:0]];
            rd_count <= count_mem[idx_reg[IDX_W-1:0]];
        end
        if (mem_we)
        begin
            color_mem[mem_waddr] <= mem_wcolor;
            count_mem[mem_waddr] <= mem_wcount;
        end
    end

    assign out_valid      = out_valid_reg;
    assign rgb_color      = color_out_reg;
    assign occurrences    = count_out_reg;
    assign rank           = rank_out_reg;
    assign last_of_report = last_out_reg;
    assign table_overflow = ovf_out_reg;
    assign empty_frame    = empty_out_reg;

    `YUVDC_ASSERT_ALWAYS(a_used_bound, used_reg <= FULL_USED, "table fill beyond its size")
    `YUVDC_ASSERT_ALWAYS(a_list_bound,
        (state_reg != S_RRD && state_reg != S_RCMP) || lcnt_reg <= limit,
        "ranked list longer than the report")
    `YUVDC_ASSERT_NEXT(a_clear_after_last,
        state_reg == S_EMIT && out_load && last_out_next,
        used_reg == '0 && !ovf_reg, "table not cleared after the report")
    `YUVDC_ASSERT_ALWAYS(a_empty_word,
        !(out_valid_reg && empty_out_reg) || (last_out_reg && count_out_reg == '0),
        "empty report word malformed")

endmodule

// ===== design/yuv_dominant_color_counter.sv =====
// ============================================================================
// YUV dominant colour counter
// Counts the RGB colours of a YUV pixel stream and reports the most common.
// ============================================================================
//  channel   direction  handshake             payload
//  in        input      in_valid / in_stall   luma, chroma_blue, chroma_red, frame_end
//  out       output     out_valid / out_stall rgb_color, occurrences, rank, flags
//  cfg       input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// A counted pixel is looked up in the table engine one entry at a time, each
// entry read and then compared; a new colour is appended or flagged as overflow.
// A frame report reads and ranks every used entry, then emits its result words.
// Reset clears the fill count and flags; the table memory is never cleared.
// A four-word queue lets the input keep accepting while the engine is busy,
// and the output register holds a word under out_stall.

module yuv_dominant_color_counter
#(
    parameter int TABLE_ENTRIES = yuvdc_pkg::TABLE_ENTRIES_DEF,
    parameter int MAX_REPORTED  = yuvdc_pkg::MAX_REPORTED_DEF,
    parameter int COUNT_WIDTH   = yuvdc_pkg::COUNT_WIDTH_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [7:0]                    luma,
    input  logic [7:0]                    chroma_blue,
    input  logic [7:0]                    chroma_red,
    input  logic                          frame_end,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [yuvdc_pkg::COLOR_W-1:0] rgb_color,
    output logic [COUNT_WIDTH-1:0]        occurrences,
    output logic [yuvdc_pkg::RANK_W-1:0]  rank,
    output logic                          last_of_report,
    output logic                          table_overflow,
    output logic                          empty_frame,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic                          cfg_index,
    input  logic [yuvdc_pkg::TOPC_W-1:0]  cfg_data
);

    logic [yuvdc_pkg::TOPC_W-1:0] top_count_reg;
    logic                         skip_reg;
    logic                         q_full;
    logic                         q_empty;
    logic                         q_push;
    logic                         q_pop;
    yuvdc_pkg::pix_word_t         push_word;
    yuvdc_pkg::pix_word_t         pop_word;

    // Configuration registers; writes are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_count_reg <= yuvdc_pkg::TOP_COUNT_RESET;
            skip_reg      <= yuvdc_pkg::SKIP_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                yuvdc_pkg::CFG_TOP_COUNT: top_count_reg <= cfg_data;
                yuvdc_pkg::CFG_SKIP:      skip_reg      <= cfg_data[0];
                default:                  top_count_reg <= top_count_reg;
            endcase
        end
    end

    yuvdc_front u_front
    (
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .luma             (luma),
        .chroma_blue      (chroma_blue),
        .chroma_red       (chroma_red),
        .frame_end        (frame_end),
        .skip_zero_chroma (skip_reg),
        .q_full           (q_full),
        .q_push           (q_push),
        .q_word           (push_word)
    );

    yuvdc_fifo u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_word (push_word),
        .full      (q_full),
        .pop       (q_pop),
        .pop_word  (pop_word),
        .empty     (q_empty)
    );

    yuvdc_back
    #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .MAX_REPORTED  (MAX_REPORTED),
        .COUNT_WIDTH   (COUNT_WIDTH)
    )
    u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_empty        (q_empty),
        .q_word         (pop_word),
        .q_pop          (q_pop),
        .top_count      (top_count_reg),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .rgb_color      (rgb_color),
        .occurrences    (occurrences),
        .rank           (rank),
        .last_of_report (last_of_report),
        .table_overflow (table_overflow),
        .empty_frame    (empty_frame)
    );

endmodule
